// File: design/arocc_pkg.sv
package arocc_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int SECTOR_BYTES  = 4096;

  localparam logic [1:0] CMD_WRITE    = 2'd0;
  localparam logic [1:0] CMD_VALIDATE = 2'd1;
  localparam logic [1:0] CMD_FIND     = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_CONFLICT  = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_BAD_INDEX = 2'd3;

  // One table entry as loaded by a write command.
  typedef struct packed {
    logic        vld;
    logic [7:0]  ftype;
    logic [31:0] start;
    logic [31:0] size;
    logic [15:0] sectors;
  } entry_t;

  typedef struct packed {
    logic       en;
    logic [7:0] idx;
    entry_t     data;
  } wr_t;

  // Query range and owner held steady for the whole walk; log_type follows the register.
  typedef struct packed {
    logic [31:0] rstart;
    logic [31:0] rend;
    logic [7:0]  own;
    logic [7:0]  log_type;
  } query_t;

  // Walk token handed from cell to cell.
  typedef struct packed {
    logic        act;
    logic        find;
    logic        done;
    logic [1:0]  status;
    logic [31:0] freed;
    logic [7:0]  slot;
  } token_t;

endpackage

// File: design/arocc_cell.sv
module arocc_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [7:0]      idx_i,
  input  arocc_pkg::wr_t    wr_i,
  input  arocc_pkg::query_t qry_i,
  input  arocc_pkg::token_t tok_i,
  output arocc_pkg::token_t tok_o
);
  import arocc_pkg::*;

  logic        vld_q, vld_d;
  logic [7:0]  ftype_q;
  logic [31:0] start_q;
  logic [31:0] size_q;
  logic [15:0] sectors_q;
  token_t      tok_q, tok_d;

  logic [31:0] span;
  logic [31:0] last;
  logic        hit;
  logic        wr_hit;

  assign wr_hit = wr_i.en && (wr_i.idx == idx_i);

  always_comb begin
    if (sectors_q != 16'd0) begin
      span = 32'(sectors_q) * 32'(SECTOR_BYTES);
    end else begin
      span = size_q;
    end
    last = start_q + span - 32'd1;
    hit  = vld_q && (size_q != 32'd0) && !((last < qry_i.rstart) || (start_q > qry_i.rend));
  end

  always_comb begin
    tok_d = tok_i;
    vld_d = vld_q;
    if (wr_hit) begin
      vld_d = wr_i.data.vld;
    end else if (tok_i.act && !tok_i.done) begin
      if (tok_i.find) begin
        if (!vld_q) begin
          tok_d.done   = 1'b1;
          tok_d.status = ST_OK;
          tok_d.slot   = idx_i;
        end
      end else if (hit) begin
        if ((qry_i.own == idx_i) || (ftype_q != qry_i.log_type)) begin
          tok_d.done   = 1'b1;
          tok_d.status = ST_CONFLICT;
        end else begin
          // An overlapped log entry is released and its span counted.
          tok_d.freed = tok_i.freed + span;
          vld_d       = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      tok_q <= '0;
    end else begin
      vld_q <= vld_d;
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_hit) begin
      ftype_q   <= wr_i.data.ftype;
      start_q   <= wr_i.data.start;
      size_q    <= wr_i.data.size;
      sectors_q <= wr_i.data.sectors;
    end
  end

  assign tok_o = tok_q;

endmodule

// File: design/alloc_range_overlap_checker_top.sv
// Channel  | Direction | Beat contents
// s_axis   | in        | tuser: cmd[1:0]; tdata: command arguments (see port)
// m_axis   | out       | tdata: status, freed_sum, free_slot
// apb      | in        | register 0 at address 0: log_type[7:0]
//
// A write command or an unused code loads the result register at the edge that
// takes the beat, so its output beat can follow at the next edge.
// Validate and find send a token down the row of TABLE_ENTRIES cells, one cell
// per cycle; the result register loads from the token of the last cell, and the
// output beat is driven from the result register.
// A new beat is taken while idle or in the cycle the result is taken.
// Reset clears all valid marks at once; no clearing pass is needed.
module alloc_range_overlap_checker_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // entry_index[7:0], entry_valid[8], entry_type[16:9], entry_start[48:17],
  // entry_size[80:49], entry_sectors[96:81], range_start[128:97],
  // range_end[160:129], own_index[168:161], zero fill[175:169]
  input  logic [175:0]        s_axis_tdata,
  // cmd[1:0]
  input  logic [1:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // status[1:0], freed_sum[33:2], free_slot[41:34], zero fill[47:42]
  output logic [47:0]         m_axis_tdata,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import arocc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [7:0]  log_type_q;
  query_t      qry_q;
  token_t      inj_q, inj_d;
  wr_t         wr;
  token_t      tok [TABLE_ENTRIES];
  token_t      tail;
  logic        in_acc;
  logic [1:0]  cmd;
  logic [7:0]  entry_index;
  logic [1:0]  res_status_q, res_status_d;
  logic [31:0] res_freed_q, res_freed_d;
  logic [7:0]  res_slot_q, res_slot_d;

  assign pready = 1'b1;
  assign prdata = (paddr == 3'd0) ? {24'd0, log_type_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log_type_q <= 8'd0;
    end else if (psel && penable && pwrite && (paddr == 3'd0)) begin
      log_type_q <= pwdata[7:0];
    end
  end

  assign cmd         = s_axis_tuser;
  assign entry_index = s_axis_tdata[7:0];
  assign s_axis_tready = (state_q == S_IDLE) || ((state_q == S_OUT) && m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {6'd0, res_slot_q, res_freed_q, res_status_q};

  always_comb begin
    wr.en           = in_acc && (cmd == CMD_WRITE) && (entry_index < 8'(TABLE_ENTRIES));
    wr.idx          = entry_index;
    wr.data.vld     = s_axis_tdata[8];
    wr.data.ftype   = s_axis_tdata[16:9];
    wr.data.start   = s_axis_tdata[48:17];
    wr.data.size    = s_axis_tdata[80:49];
    wr.data.sectors = s_axis_tdata[96:81];
  end

  assign tail = tok[TABLE_ENTRIES-1];

  always_comb begin
    state_d      = state_q;
    inj_d        = '0;
    res_status_d = res_status_q;
    res_freed_d  = res_freed_q;
    res_slot_d   = res_slot_q;
    case (state_q)
      S_WALK: begin
        if (tail.act) begin
          res_status_d = tail.status;
          res_freed_d  = tail.freed;
          res_slot_d   = tail.slot;
          state_d      = S_OUT;
        end
      end
      S_OUT: begin
        if (m_axis_tready) begin
          state_d = S_IDLE;
        end
      end
      default: begin
      end
    endcase
    if (in_acc) begin
      res_status_d = ST_OK;
      res_freed_d  = 32'd0;
      res_slot_d   = 8'd0;
      state_d      = S_OUT;
      case (cmd)
        CMD_WRITE: begin
          if (entry_index >= 8'(TABLE_ENTRIES)) begin
            res_status_d = ST_BAD_INDEX;
          end
        end
        CMD_VALIDATE: begin
          inj_d.act = 1'b1;
          state_d   = S_WALK;
        end
        CMD_FIND: begin
          inj_d.act    = 1'b1;
          inj_d.find   = 1'b1;
          inj_d.status = ST_FULL;
          state_d      = S_WALK;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      inj_q   <= '0;
    end else begin
      state_q <= state_d;
      inj_q   <= inj_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_freed_q  <= res_freed_d;
    res_slot_q   <= res_slot_d;
    if (in_acc) begin
      qry_q.rstart <= s_axis_tdata[128:97];
      qry_q.rend   <= s_axis_tdata[160:129];
      qry_q.own    <= s_axis_tdata[168:161];
    end
    qry_q.log_type <= log_type_q;
  end

  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
    arocc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (8'(k)),
      .wr_i   (wr),
      .qry_i  (qry_q),
      .tok_i  ((k == 0) ? inj_q : tok[(k == 0) ? 0 : k-1]),
      .tok_o  (tok[k])
    );
  end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import arocc_pkg::*;

  localparam logic [1:0]  CMD_UNUSED   = 2'd3;
  localparam logic [2:0]  REG_LOG_TYPE = 3'd0;
  localparam logic [31:0] SECTOR_SPAN  = SECTOR_BYTES;
  localparam int          CYCLE_LIMIT  = 500000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  idx;
    logic        vld;
    logic [7:0]  ftype;
    logic [31:0] estart;
    logic [31:0] esize;
    logic [15:0] esect;
    logic [31:0] rstart;
    logic [31:0] rend;
    logic [7:0]  own;
  } table_cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] freed;
    logic [7:0]  slot;
  } table_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [175:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [47:0]  m_axis_tdata;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  alloc_range_overlap_checker_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the file index table and the log type register.
  logic        tbl_vld   [TABLE_ENTRIES];
  logic [7:0]  tbl_type  [TABLE_ENTRIES];
  logic [31:0] tbl_start [TABLE_ENTRIES];
  logic [31:0] tbl_size  [TABLE_ENTRIES];
  logic [15:0] tbl_sect  [TABLE_ENTRIES];
  logic [7:0]  cfg_log_type = 8'd0;

  table_cmd_t    cmd_queue[$];
  table_result_t expected_results[$];
  table_cmd_t    cmd_on_bus;
  int            queued_total = 0;
  int            error_count = 0;
  int            cycle_count = 0;
  bit            in_beat_taken = 1'b0;
  bit            quiet = 1'b0;
  bit            long_hold_req = 1'b0;
  int            send_gap = 0;
  int            recv_stall = 0;
  int            long_hold = 0;

  function automatic table_result_t predict_table_op(input table_cmd_t c);
    table_result_t r;
    logic [31:0]   span;
    logic [31:0]   last_byte;
    bit            stop;
    r.status = ST_OK;
    r.freed  = '0;
    r.slot   = '0;
    stop     = 1'b0;
    case (c.cmd)
      CMD_WRITE: begin
        if (c.idx >= TABLE_ENTRIES) begin
          r.status = ST_BAD_INDEX;
        end else begin
          tbl_vld[c.idx]   = c.vld;
          tbl_type[c.idx]  = c.ftype;
          tbl_start[c.idx] = c.estart;
          tbl_size[c.idx]  = c.esize;
          tbl_sect[c.idx]  = c.esect;
        end
      end
      CMD_VALIDATE: begin
        for (int k = 0; k < TABLE_ENTRIES; k++) begin
          if (!stop && tbl_vld[k] && tbl_size[k] != 32'd0) begin
            span = (tbl_sect[k] != 16'd0) ? {16'd0, tbl_sect[k]} * SECTOR_SPAN : tbl_size[k];
            last_byte = tbl_start[k] + span - 32'd1;
            if (!(last_byte < c.rstart || tbl_start[k] > c.rend)) begin
              if (k == c.own || tbl_type[k] != cfg_log_type) begin
                r.status = ST_CONFLICT;
                stop = 1'b1;
              end else begin
                r.freed = r.freed + span;
                tbl_vld[k] = 1'b0;
              end
            end
          end
        end
      end
      CMD_FIND: begin
        r.status = ST_FULL;
        for (int k = 0; k < TABLE_ENTRIES; k++) begin
          if (!stop && !tbl_vld[k]) begin
            r.status = ST_OK;
            r.slot = k[7:0];
            stop = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic table_cmd_t random_cmd();
    table_cmd_t c;
    c.cmd    = 2'($urandom_range(0, 3));
    c.idx    = 8'($urandom_range(0, 255));
    c.vld    = 1'($urandom_range(0, 1));
    c.ftype  = 8'($urandom_range(0, 255));
    c.estart = $urandom;
    c.esize  = $urandom;
    c.esect  = 16'($urandom_range(0, 65535));
    c.rstart = $urandom;
    c.rend   = $urandom;
    c.own    = 8'($urandom_range(0, 255));
    return c;
  endfunction

  task automatic push_cmd(input table_cmd_t c);
    cmd_queue.push_back(c);
    queued_total++;
  endtask

  task automatic push_write(input logic [7:0] idx, input logic vld, input logic [7:0] ftype,
                            input logic [31:0] start, input logic [31:0] size,
                            input logic [15:0] sect);
    table_cmd_t c;
    c = random_cmd();
    c.cmd    = CMD_WRITE;
    c.idx    = idx;
    c.vld    = vld;
    c.ftype  = ftype;
    c.estart = start;
    c.esize  = size;
    c.esect  = sect;
    push_cmd(c);
  endtask

  task automatic push_validate(input logic [31:0] rs, input logic [31:0] re,
                               input logic [7:0] own);
    table_cmd_t c;
    c = random_cmd();
    c.cmd    = CMD_VALIDATE;
    c.rstart = rs;
    c.rend   = re;
    c.own    = own;
    push_cmd(c);
  endtask

  task automatic push_find();
    table_cmd_t c;
    c = random_cmd();
    c.cmd = CMD_FIND;
    push_cmd(c);
  endtask

  task automatic set_log_type(input logic [7:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= REG_LOG_TYPE;
    pwdata  <= {24'd0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_log_type = value;
  endtask

  // Checked at the rising edge, where the bus signals driven at the falling
  // edge are settled.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (cmd_queue.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
  endtask

  task automatic run_directed();
    table_cmd_t c;
    push_find();
    push_validate(32'd0, 32'hFFFF_FFFF, 8'd0);
    push_write(8'd16, 1'b1, 8'hFF, 32'h0, 32'h10, 16'd0);
    push_write(8'd255, 1'b1, 8'hFF, 32'h0, 32'h10, 16'd0);
    // Fill every slot; slot 7 is not a log file, slot 3 has no data, slot 1
    // uses the largest sector count and slots 14 and 15 wrap past the top.
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      push_write(k[7:0], 1'b1, (k == 7) ? 8'h00 : 8'hFF,
                 (k == 15) ? 32'hFFFF_FF00 : (k == 14) ? 32'hFFFF_FFFF : k << 12,
                 (k == 3) ? 32'd0 : (k == 14) ? 32'hFFFF_FFFF : 32'h800 + k,
                 (k == 1) ? 16'hFFFF : 16'd0);
    end
    push_find();
    push_validate(32'h3000, 32'h3000, 8'd255);
    push_find();
    push_validate(32'h7000, 32'h7000, 8'd255);
    push_validate(32'h2000, 32'h2000, 8'd2);
    push_validate(32'hF000_0000, 32'h10, 8'd255);
    c = random_cmd();
    c.cmd = CMD_UNUSED;
    push_cmd(c);
    push_write(8'd4, 1'b0, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    push_find();
  endtask

  task automatic run_random(input int n_items);
    table_cmd_t  c;
    logic [31:0] win_base;
    logic [31:0] rs;
    logic [31:0] re;
    int          target;
    int          pick;
    target   = queued_total + n_items;
    win_base = $urandom & 32'hFFF0_0000;
    while (queued_total < target) begin
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        // A few entries around one window, then a request inside it.
        repeat ($urandom_range(1, 5)) begin
          push_write(8'($urandom_range(0, 15)), $urandom_range(0, 7) != 0,
                     ($urandom_range(0, 3) != 0) ? cfg_log_type : 8'($urandom_range(0, 255)),
                     win_base + $urandom_range(0, 32'h1FFFF),
                     ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom_range(1, 32'h4000),
                     ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 4)) : 16'd0);
        end
        rs = win_base + $urandom_range(0, 32'h1FFFF);
        re = rs + $urandom_range(0, 32'h8000);
        if ($urandom_range(0, 9) == 0) begin
          push_validate(re, rs, 8'($urandom_range(0, 15)));
        end else begin
          push_validate(rs, re, ($urandom_range(0, 3) == 0) ? 8'($urandom_range(16, 255))
                                                             : 8'($urandom_range(0, 15)));
        end
        if ($urandom_range(0, 1) == 0) push_find();
      end else if (pick == 6) begin
        push_find();
      end else begin
        c = random_cmd();
        if (pick == 7) c.cmd = CMD_WRITE;
        else if (pick == 8) c.cmd = CMD_VALIDATE;
        push_cmd(c);
      end
    end
  endtask

  // Sender: a new beat goes out once the previous one is taken.
  always @(negedge clk_i) begin
    logic nxt_valid;
    nxt_valid = s_axis_tvalid;
    if (!s_axis_tvalid || in_beat_taken) begin
      nxt_valid = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (cmd_queue.size() != 0) begin
        if (!quiet && $urandom_range(0, 3) == 0) begin
          send_gap = $urandom_range(0, 7);
        end else begin
          cmd_on_bus = cmd_queue.pop_front();
          s_axis_tuser <= cmd_on_bus.cmd;
          s_axis_tdata <= {7'd0, cmd_on_bus.own, cmd_on_bus.rend, cmd_on_bus.rstart,
                           cmd_on_bus.esect, cmd_on_bus.esize, cmd_on_bus.estart,
                           cmd_on_bus.ftype, cmd_on_bus.vld, cmd_on_bus.idx};
          nxt_valid = 1'b1;
        end
      end
      s_axis_tvalid <= nxt_valid;
    end
  end

  always @(posedge clk_i) begin
    in_beat_taken = s_axis_tvalid && s_axis_tready;
    if (in_beat_taken) expected_results.push_back(predict_table_op(cmd_on_bus));
  end

  // Receiver: random stalls, plus one long hold-off so the block backs up.
  always @(negedge clk_i) begin
    logic nxt_ready;
    nxt_ready = 1'b1;
    if (long_hold > 0) begin
      long_hold--;
      nxt_ready = 1'b0;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      long_hold = 400;
      nxt_ready = 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall--;
      nxt_ready = 1'b0;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      recv_stall = $urandom_range(0, 7);
      nxt_ready = 1'b0;
    end
    m_axis_tready <= nxt_ready;
  end

  always @(posedge clk_i) begin
    table_result_t want;
    table_result_t got;
    if (m_axis_tvalid && m_axis_tready) begin
      got.status = m_axis_tdata[1:0];
      got.freed  = m_axis_tdata[33:2];
      got.slot   = m_axis_tdata[41:34];
      if (expected_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result beat, actual %h", $time, got);
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status) begin
          error_count++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        end
        if (got.freed !== want.freed) begin
          error_count++;
          $display("%0t: freed sum expected %h actual %h", $time, want.freed, got.freed);
        end
        if (got.slot !== want.slot) begin
          error_count++;
          $display("%0t: free_slot expected %0d actual %0d", $time, want.slot, got.slot);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[alloc_range_overlap_checker_top] ERROR");
      $finish;
    end
  end

  initial begin
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      tbl_vld[k]   = 1'b0;
      tbl_type[k]  = '0;
      tbl_start[k] = '0;
      tbl_size[k]  = '0;
      tbl_sect[k]  = '0;
    end
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    set_log_type(8'hFF);
    run_directed();
    wait_drained();

    set_log_type(8'h00);
    long_hold_req = 1'b1;
    run_random(300);
    wait_drained();

    set_log_type(8'($urandom_range(0, 255)));
    run_random(300);
    wait_drained();

    set_log_type(8'($urandom_range(0, 255)));
    run_random(300);
    wait_drained();

    quiet = 1'b1;
    set_log_type(8'($urandom_range(0, 255)));
    run_random(300);
    wait_drained();

    repeat (2 * TABLE_ENTRIES + 4) @(posedge clk_i);
    if (error_count == 0) begin
      $display("[alloc_range_overlap_checker_top] OK");
    end else begin
      $display("[alloc_range_overlap_checker_top] ERROR");
    end
    $finish;
  end

endmodule
